/* rtl/smb2hp_pkg.sv */
`default_nettype none
package smb2hp_pkg;

  localparam int unsigned HDR_BYTES  = 64;
  localparam int unsigned KEPT_BYTES = 48;
  localparam int unsigned CNT_W      = 7;

  localparam logic [31:0] STATUS_MORE_PROCESSING = 32'hC000_0016;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_SHORT     = 2'd1,
    RC_BAD_MAGIC = 2'd2
  } rcode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    rcode_t      result_code;
    logic        status_is_error;
    logic [15:0] structure_size;
    logic [15:0] credit_cost;
    logic [31:0] nt_status;
    logic [15:0] command_code;
    logic [15:0] credit_grant;
    logic [31:0] header_flags;
    logic [31:0] next_offset;
    logic [63:0] msg_number;
    logic [63:0] id_word;
    logic [63:0] sess_uid;
  } out_item_t;

  typedef logic [KEPT_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic done;
    logic len_ok;
    logic magic_ok;
  } msg_stat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hFE;
      2'd1:    b = 8'h53;
      2'd2:    b = 8'h4D;
      default: b = 8'h42;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/smb2hp_capture.sv */
`default_nettype none
module smb2hp_capture (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire smb2hp_pkg::in_item_t   item,
  output smb2hp_pkg::msg_stat_t       stat,
  output smb2hp_pkg::hdr_bytes_t      hdr
);
  import smb2hp_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic             magic_r, magic_nxt, magic_upd;
  hdr_bytes_t       store_r, store_nxt;

  always_comb begin
    count_inc = (count_r < CNT_W'(HDR_BYTES)) ? count_r + CNT_W'(1) : count_r;
    magic_upd = magic_r;
    if (count_r < CNT_W'(4) && item.data_byte != magic_byte(count_r[1:0])) begin
      magic_upd = 1'b0;
    end
    store_nxt = store_r;
    if (count_r < CNT_W'(KEPT_BYTES)) begin
      store_nxt = {item.data_byte, store_r[KEPT_BYTES-1:1]};
    end
    count_nxt = item.last_byte ? '0 : count_inc;
    magic_nxt = item.last_byte ? 1'b1 : magic_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      magic_r <= 1'b1;
    end else if (fire) begin
      count_r <= count_nxt;
      magic_r <= magic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      store_r <= store_nxt;
    end
  end

  assign stat.done     = fire & item.last_byte;
  assign stat.len_ok   = (count_inc == CNT_W'(HDR_BYTES));
  assign stat.magic_ok = magic_upd;
  assign hdr           = store_r;

endmodule
`default_nettype wire

/* rtl/smb2hp_result.sv */
`default_nettype none
module smb2hp_result (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire smb2hp_pkg::msg_stat_t  stat,
  input  wire smb2hp_pkg::hdr_bytes_t hdr,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output smb2hp_pkg::out_item_t       out_item,
  output logic                        space
);
  import smb2hp_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic [31:0] st;

  assign space = !valid_r || out_ready;

  always_comb begin
    st       = hdr[11:8];
    item_nxt = '0;
    if (!stat.len_ok) begin
      item_nxt.result_code = RC_SHORT;
    end else if (!stat.magic_ok) begin
      item_nxt.result_code = RC_BAD_MAGIC;
    end else begin
      item_nxt.result_code     = RC_OK;
      item_nxt.status_is_error = (st[31:30] == 2'b11) && (st != STATUS_MORE_PROCESSING);
      item_nxt.structure_size  = hdr[5:4];
      item_nxt.credit_cost     = hdr[7:6];
      item_nxt.nt_status       = st;
      item_nxt.command_code    = hdr[13:12];
      item_nxt.credit_grant    = hdr[15:14];
      item_nxt.header_flags    = hdr[19:16];
      item_nxt.next_offset     = hdr[23:20];
      item_nxt.msg_number      = hdr[31:24];
      item_nxt.id_word         = hdr[39:32];
      item_nxt.sess_uid        = hdr[47:40];
    end
    valid_nxt = stat.done || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

/* rtl/smb2_header_parser.sv */
// The result item of a message is registered and appears in the cycle after its last byte is accepted.
// Throughput: one byte item per cycle; results drain through a single output register.
// A byte is taken whenever the output register is empty or being read in the same cycle.
// Reset (synchronous, rst_n low) clears the byte count and output valid, and sets the magic flag;
// the 48-byte header shift line is not reset.
`default_nettype none
module smb2_header_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire smb2hp_pkg::in_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output smb2hp_pkg::out_item_t      out_item
);
  import smb2hp_pkg::*;

  logic       fire;
  logic       space;
  msg_stat_t  stat;
  hdr_bytes_t hdr;

  assign fire     = in_valid && in_ready;
  assign in_ready = space;

  smb2hp_capture u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item),
    .stat  (stat),
    .hdr   (hdr)
  );

  smb2hp_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .hdr       (hdr),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .space     (space)
  );

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.last_byte) |=> out_valid)
    else $error("last byte accepted without a result");

  a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.result_code != RC_OK) |->
      (!out_item.status_is_error && out_item.nt_status == '0 &&
       out_item.sess_uid == '0 && out_item.msg_number == '0))
    else $error("nonzero fields on a failed result");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.result_code == RC_OK || out_item.result_code == RC_SHORT ||
                   out_item.result_code == RC_BAD_MAGIC))
    else $error("illegal result code");

  a_no_result_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(in_valid && in_ready && in_item.last_byte)) |=> !out_valid)
    else $error("result without a last byte");

endmodule
`default_nettype wire

/* tb/smb2_header_parser_test.sv */
`timescale 1ns / 1ps
module smb2_header_parser_test;
  import smb2hp_pkg::*;

  class hdr_scoreboard;
    logic [6:0] byte_count;
    bit         magic_good;
    logic [7:0] hdr [KEPT_BYTES];
    out_item_t  header_q[$];
    int         errors;

    function new();
      byte_count = '0;
      magic_good = 1'b1;
      errors     = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function logic [63:0] le_field(int off, int len);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < len; i++) v[8*i +: 8] = hdr[off+i];
      return v;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]  magic [4];
      logic [31:0] st;
      out_item_t   r;
      magic = '{8'hFE, "S", "M", "B"};
      if (byte_count < 4 && it.data_byte != magic[byte_count[1:0]]) magic_good = 1'b0;
      if (byte_count < KEPT_BYTES) hdr[byte_count] = it.data_byte;
      if (byte_count < HDR_BYTES) byte_count++;
      if (!it.last_byte) return;
      r = '0;
      if (byte_count < HDR_BYTES) begin
        r.result_code = RC_SHORT;
      end else if (!magic_good) begin
        r.result_code = RC_BAD_MAGIC;
      end else begin
        st = 32'(le_field(8, 4));
        r.result_code     = RC_OK;
        r.status_is_error = (st[31:30] == 2'b11) && (st != STATUS_MORE_PROCESSING);
        r.structure_size  = 16'(le_field(4, 2));
        r.credit_cost     = 16'(le_field(6, 2));
        r.nt_status       = st;
        r.command_code    = 16'(le_field(12, 2));
        r.credit_grant    = 16'(le_field(14, 2));
        r.header_flags    = 32'(le_field(16, 4));
        r.next_offset     = 32'(le_field(20, 4));
        r.msg_number      = le_field(24, 8);
        r.id_word         = le_field(32, 8);
        r.sess_uid        = le_field(40, 8);
      end
      header_q.push_back(r);
      byte_count = '0;
      magic_good = 1'b1;
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (header_q.size() == 0) begin
        $error("result item with none pending: %p", got);
        errors++;
        return;
      end
      want = header_q.pop_front();
      cmp("result_code", 64'(want.result_code), 64'(got.result_code));
      cmp("status_is_error", 64'(want.status_is_error), 64'(got.status_is_error));
      cmp("structure_size", 64'(want.structure_size), 64'(got.structure_size));
      cmp("credit_cost", 64'(want.credit_cost), 64'(got.credit_cost));
      cmp("nt_status", 64'(want.nt_status), 64'(got.nt_status));
      cmp("command_code", 64'(want.command_code), 64'(got.command_code));
      cmp("credit_grant", 64'(want.credit_grant), 64'(got.credit_grant));
      cmp("header_flags", 64'(want.header_flags), 64'(got.header_flags));
      cmp("next_offset", 64'(want.next_offset), 64'(got.next_offset));
      cmp("msg_number", want.msg_number, got.msg_number);
      cmp("id_word", want.id_word, got.id_word);
      cmp("sess_uid", want.sess_uid, got.sess_uid);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  hdr_scoreboard sb;
  bit            hold_req;
  logic [7:0]    msg[$];
  int            sent_bytes;
  int            n_msgs;

  smb2_header_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_item);
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  task automatic put_byte(logic [7:0] b, bit last, bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_msg(bit fast);
    foreach (msg[i]) put_byte(msg[i], i == msg.size() - 1, fast);
    sent_bytes += msg.size();
    n_msgs++;
  endtask

  task automatic put_le(int off, logic [31:0] v);
    for (int i = 0; i < 4; i++)
      if (off + i < msg.size()) msg[off+i] = v[8*i +: 8];
  endtask

  task automatic build_msg(int len, logic [31:0] status, logic [31:0] flags);
    msg.delete();
    repeat (len) msg.push_back(8'($urandom_range(0, 255)));
    put_le(0, 32'h424D_53FE);
    put_le(8, status);
    put_le(16, flags);
  endtask

  task automatic corrupt_magic(int pos);
    if (pos < msg.size()) msg[pos] = msg[pos] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic fill_header(logic [7:0] v);
    for (int i = 4; i < 64; i++) msg[i] = v;
  endtask

  function automatic logic [31:0] pick_status();
    logic [31:0] s;
    case ($urandom_range(0, 4))
      0:       s = 32'h0;
      1:       s = STATUS_MORE_PROCESSING;
      2:       s = {2'b11, 30'($urandom)};
      3:       s = {2'b11, 30'h16} ^ {30'h0, 2'($urandom)};
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // receiver: random stalls, occasional long hold to back up the input
  initial begin
    int  gap;
    int  count;
    bit  fast;
    out_ready = 1'b0;
    count     = 0;
    fast      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (count % 32 == 0) fast = ($urandom_range(0, 2) == 0);
      count++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int r;
    int len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    hold_req   = 1'b0;
    sent_bytes = 0;
    n_msgs     = 0;
    sb         = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    build_msg(64, 32'h0, 32'h0);                  send_msg(1'b0);
    build_msg(64, STATUS_MORE_PROCESSING, 32'h2); send_msg(1'b1);
    build_msg(64, 32'hC000_0001, 32'h0);          send_msg(1'b0);
    build_msg(64, 32'h8000_0000, 32'h0);          send_msg(1'b0);
    build_msg(64, 32'h4000_0000, 32'h2);          send_msg(1'b0);
    build_msg(64, 32'h0, 32'h0); fill_header(8'hFF); send_msg(1'b1);
    build_msg(64, 32'h0, 32'h0); fill_header(8'h00); send_msg(1'b0);
    build_msg(1, 32'h0, 32'h0);                   send_msg(1'b0);
    build_msg(4, 32'h0, 32'h0);                   send_msg(1'b0);
    build_msg(63, 32'hC000_0001, 32'h0);          send_msg(1'b1);
    for (int p = 0; p < 4; p++) begin
      build_msg(64, 32'hC000_0001, 32'h0);
      corrupt_magic(p);
      send_msg(1'b0);
    end
    build_msg(10, 32'h0, 32'h0); corrupt_magic(0); send_msg(1'b0);
    build_msg(65, pick_status(), $urandom);       send_msg(1'b0);
    build_msg(200, pick_status(), $urandom);      send_msg(1'b1);
    build_msg(130, pick_status(), $urandom); corrupt_magic(2); send_msg(1'b0);

    // back-pressure: receiver holds off while short messages stream in
    hold_req = 1'b1;
    repeat (30) begin
      build_msg($urandom_range(1, 3), 32'h0, 32'h0);
      send_msg(1'b1);
    end

    // random
    while (sent_bytes < 1400 || n_msgs < 50) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 140) : 64;
        build_msg(len, pick_status(), $urandom);
      end else if (r < 80) begin
        build_msg($urandom_range(64, 70), pick_status(), $urandom);
        corrupt_magic($urandom_range(0, 3));
      end else begin
        build_msg($urandom_range(1, 63), pick_status(), $urandom);
        if ($urandom_range(0, 1)) corrupt_magic($urandom_range(0, 3));
      end
      send_msg($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (sb.header_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/smb2hp_pkg.sv
rtl/smb2hp_capture.sv
rtl/smb2hp_result.sv
rtl/smb2_header_parser.sv
tb/smb2_header_parser_test.sv
